/* rtl/jsfr_pkg.sv */
// jsfr_pkg: shared types and constants for the dual-stream jsf32 range generator
// item structs, command codes, microcode control word layout
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jsfr_pkg;

   // command codes
   localparam logic [1:0] CMD_SEED  = 2'd0;
   localparam logic [1:0] CMD_RANGE = 2'd1;
   localparam logic [1:0] CMD_RAW   = 2'd2;

   localparam logic [31:0] JSF_SEED_A = 32'hf1ea5eed;
   localparam int unsigned JSF_ROT_B  = 27;
   localparam int unsigned JSF_ROT_C  = 17;
   localparam logic [5:0]  WARMUP_ROUNDS = 6'd20;
   localparam logic [5:0]  DIV_BITS      = 6'd32;
   localparam logic [31:0] WORD_MAX      = 32'hffff_ffff;

   typedef struct packed {
      logic [1:0]         command;
      logic               stream;
      logic [63:0]        seed_value;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
   } req_type;

   typedef struct packed {
      logic signed [31:0] range_value;
      logic [63:0]        raw_value;
      logic [31:0]        draw_count;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } jsf_word_type;

   // microcode fields
   typedef enum logic [2:0] {
      W_NONE, W_LOAD, W_SEED, W_ROUND, W_STORE_ALL, W_STORE_SEL
   } work_op_type;

   typedef enum logic [2:0] {
      D_NONE, D_START_N, D_START_DRAW, D_STEP, D_SAVE
   } div_op_type;

   typedef enum logic [1:0] {
      C_NONE, C_LOAD_ROUNDS, C_LOAD_BITS, C_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      J_NEXT, J_ALWAYS, J_CNT_MORE, J_REJECT
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      work_op_type work;
      div_op_type  div;
      cnt_op_type  cnt;
      cond_type    cond;
      upc_type     target;
      logic        capture_hi;
      logic        respond;
   } ctl_word_type;

   localparam ctl_word_type CTL_IDLE = '{W_NONE, D_NONE, C_NONE, J_NEXT, 4'd0, 1'b0, 1'b0};

   // datapath status seen by the sequencer
   typedef struct packed {
      logic cnt_more;
      logic reject;
      logic range_ok;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/jsfr_useq.sv */
// jsfr_useq: microcode rom, step counter and jump logic
// depends on jsfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsfr_useq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        command,
   input  jsfr_pkg::stat_type     stat,
   output jsfr_pkg::ctl_word_type ctl,
   output logic                   busy,
   output logic                   rsp_valid
);
   import jsfr_pkg::*;

   // program entry points
   localparam upc_type U_SEED  = 4'd0;
   localparam upc_type U_RANGE = 4'd3;
   localparam upc_type U_DRAW  = 4'd6;
   localparam upc_type U_RESP  = 4'd10;
   localparam upc_type U_RAW   = 4'd11;

   function automatic ctl_word_type ucode(input upc_type addr);
      ctl_word_type w;
      w = CTL_IDLE;
      case (addr)
         4'd0:  w = '{W_SEED,      D_NONE,       C_LOAD_ROUNDS, J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd1:  w = '{W_ROUND,     D_NONE,       C_DEC,         J_CNT_MORE, 4'd1,    1'b0, 1'b0};
         4'd2:  w = '{W_STORE_ALL, D_NONE,       C_NONE,        J_ALWAYS,   U_RESP,  1'b0, 1'b0};
         4'd3:  w = '{W_LOAD,      D_START_N,    C_LOAD_BITS,   J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd4:  w = '{W_NONE,      D_STEP,       C_DEC,         J_CNT_MORE, 4'd4,    1'b0, 1'b0};
         4'd5:  w = '{W_NONE,      D_SAVE,       C_NONE,        J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd6:  w = '{W_ROUND,     D_NONE,       C_NONE,        J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd7:  w = '{W_NONE,      D_START_DRAW, C_LOAD_BITS,   J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd8:  w = '{W_NONE,      D_STEP,       C_DEC,         J_CNT_MORE, 4'd8,    1'b0, 1'b0};
         4'd9:  w = '{W_STORE_SEL, D_NONE,       C_NONE,        J_REJECT,   U_DRAW,  1'b0, 1'b0};
         4'd10: w = '{W_NONE,      D_NONE,       C_NONE,        J_NEXT,     4'd0,    1'b0, 1'b1};
         4'd11: w = '{W_LOAD,      D_NONE,       C_NONE,        J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd12: w = '{W_ROUND,     D_NONE,       C_NONE,        J_NEXT,     4'd0,    1'b0, 1'b0};
         4'd13: w = '{W_ROUND,     D_NONE,       C_NONE,        J_NEXT,     4'd0,    1'b1, 1'b0};
         4'd14: w = '{W_STORE_SEL, D_NONE,       C_NONE,        J_ALWAYS,   U_RESP,  1'b0, 1'b0};
         default: w = '{W_NONE,    D_NONE,       C_NONE,        J_ALWAYS,   U_RESP,  1'b0, 1'b0};
      endcase
      return w;
   endfunction

   upc_type pc_ff, pc_in;
   logic    busy_ff, busy_in;
   logic    valid_ff, valid_in;
   upc_type entry;
   ctl_word_type word;

   assign word = ucode(pc_ff);
   assign ctl  = busy_ff ? word : CTL_IDLE;

   always_comb begin
      case (command)
         CMD_SEED:  entry = U_SEED;
         CMD_RANGE: entry = stat.range_ok ? U_RANGE : U_RESP;
         CMD_RAW:   entry = U_RAW;
         default:   entry = U_RESP;
      endcase
   end

   always_comb begin
      pc_in    = pc_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      if (accept) begin
         pc_in   = entry;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (word.cond)
            J_NEXT:     pc_in = pc_ff + 4'd1;
            J_ALWAYS:   pc_in = word.target;
            J_CNT_MORE: pc_in = stat.cnt_more ? word.target : pc_ff + 4'd1;
            J_REJECT:   pc_in = stat.reject ? word.target : pc_ff + 4'd1;
            default:    pc_in = U_RESP;
         endcase
         if (word.respond) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

/* rtl/jsfr_dpath.sv */
// jsfr_dpath: generator words, jsf round, serial divider, draw counter, result register
// depends on jsfr_pkg; driven by control words from jsfr_useq
`timescale 1ns / 1ps
`default_nettype none

module jsfr_dpath #(
   parameter int NUM_STREAMS = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  jsfr_pkg::req_type      req_item,
   input  jsfr_pkg::ctl_word_type ctl,
   output jsfr_pkg::stat_type     stat,
   output jsfr_pkg::rsp_type      rsp_item
);
   import jsfr_pkg::*;

   localparam int SEL_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned k);
      return (v << k) | (v >> (32 - k));
   endfunction

   function automatic jsf_word_type jsf_round(input jsf_word_type g);
      jsf_word_type r;
      logic [31:0]  e;
      e   = g.a - rotl(g.b, JSF_ROT_B);
      r.a = g.b ^ rotl(g.c, JSF_ROT_C);
      r.b = g.c + g.d;
      r.c = g.d + e;
      r.d = e + r.a;
      return r;
   endfunction

   // latched command
   logic [1:0]       cmd_ff;
   logic [SEL_W-1:0] sel_ff;
   logic [63:0]      seed_ff;
   logic [31:0]      lower_ff;
   logic [31:0]      n_ff;
   logic             empty_ff;
   logic             err_ff;
   logic [31:0]      count_ff;

   // generator state
   jsf_word_type store_ff [NUM_STREAMS];
   jsf_word_type work_ff, work_in;
   logic [31:0]  hi_ff;

   // divider
   logic [31:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [31:0] div_ff;
   logic [5:0]  cnt_ff, cnt_in;

   rsp_type rsp_ff, rsp_in;

   // interval check at accept
   logic [32:0]      diff;
   logic             empty_now;
   logic             err_now;
   logic [SEL_W-1:0] sel_now;
   logic             counted;

   assign diff      = {req_item.upper_bound[31], req_item.upper_bound}
                    - {req_item.lower_bound[31], req_item.lower_bound};
   assign empty_now = diff[32] || (diff == 33'd0);
   assign err_now   = (diff == {1'b0, WORD_MAX});
   assign sel_now   = (NUM_STREAMS > 1) ? SEL_W'(req_item.stream) : '0;
   assign counted   = (sel_now == '0)
                    && ((req_item.command == CMD_RAW)
                        || ((req_item.command == CMD_RANGE) && !empty_now && !err_now));

   assign stat.range_ok = !empty_now && !err_now;
   assign stat.cnt_more = (cnt_ff != 6'd1);
   assign stat.reject   = (q_ff >= n_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_item.command;
         sel_ff   <= sel_now;
         seed_ff  <= req_item.seed_value;
         lower_ff <= req_item.lower_bound;
         n_ff     <= diff[31:0] + 32'd1;
         empty_ff <= empty_now;
         err_ff   <= err_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept && counted) begin
         count_ff <= count_ff + 32'd1;
      end
   end

   // working copy of the selected generator
   always_comb begin
      case (ctl.work)
         W_LOAD:  work_in = store_ff[sel_ff];
         W_SEED:  work_in = '{JSF_SEED_A, seed_ff[31:0],
                              seed_ff[31:0] ^ seed_ff[63:32], seed_ff[31:0]};
         W_ROUND: work_in = jsf_round(work_ff);
         default: work_in = work_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (ctl.capture_hi) begin
         hi_ff <= work_ff.d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STREAMS; s++) begin
            store_ff[s] <= '0;
         end
      end else if (ctl.work == W_STORE_ALL) begin
         for (int s = 0; s < NUM_STREAMS; s++) begin
            store_ff[s] <= work_ff;
         end
      end else if (ctl.work == W_STORE_SEL) begin
         store_ff[sel_ff] <= work_ff;
      end
   end

   // restoring divider, one quotient bit per step
   logic [32:0] trial;
   logic        fits;

   assign trial = {rem_ff, q_ff[31]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      case (ctl.div)
         D_START_N: begin
            q_in   = WORD_MAX;
            rem_in = '0;
            dsr_in = n_ff;
         end
         D_START_DRAW: begin
            q_in   = work_ff.d;
            rem_in = '0;
            dsr_in = div_ff;
         end
         D_STEP: begin
            q_in   = {q_ff[30:0], fits};
            rem_in = fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (ctl.div == D_SAVE) begin
         div_ff <= q_ff;
      end
   end

   always_comb begin
      case (ctl.cnt)
         C_LOAD_ROUNDS: cnt_in = WARMUP_ROUNDS;
         C_LOAD_BITS:   cnt_in = DIV_BITS;
         C_DEC:         cnt_in = cnt_ff - 6'd1;
         default:       cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (ctl.respond) begin
         rsp_in            = '0;
         rsp_in.draw_count = count_ff;
         case (cmd_ff)
            CMD_SEED: rsp_in.raw_value = seed_ff;
            CMD_RANGE: begin
               if (empty_ff) begin
                  rsp_in.range_value = lower_ff;
               end else if (err_ff) begin
                  rsp_in.range_error = 1'b1;
               end else begin
                  rsp_in.range_value = lower_ff + q_ff;
               end
            end
            CMD_RAW: rsp_in.raw_value = {hi_ff, work_ff.d};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

/* rtl/dual_stream_jsf32_range_rng.sv */
// dual_stream_jsf32_range_rng: top level of the jsf32 generator block
// depends on jsfr_pkg, jsfr_useq, jsfr_dpath
`timescale 1ns / 1ps
`default_nettype none

// Two or more jsf32 small-fast generators behind a start/busy command port.
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done, and the one result shows on rsp_item with rsp_valid
// high for a single cycle, in the cycle busy falls. The receiver cannot
// stall: rsp_valid is a strobe and the result must be captured when it shows.
// Each item runs as a program of a small microcode sequencer that steps a plain
// datapath once per cycle:
//   seed        - twenty warmup rounds, one per cycle, on one
//                 working copy that is then written to every stream
//   raw 64-bit  - load, two rounds, store to the selected stream
//   range draw  - one or more tries; each try is one round plus
//                 a 32-bit shift-subtract divide, and one more such divide
//                 up front forms 0xffffffff / n; one try for most intervals
//   empty, reversed or full range, unknown command - result step only
// A new item can be started in the cycle rsp_valid is high.
// After reset all generators are zero and keep yielding zero until seeded.

module dual_stream_jsf32_range_rng #(
   parameter int NUM_STREAMS = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  jsfr_pkg::req_type req_item,
   output logic              rsp_valid,
   output jsfr_pkg::rsp_type rsp_item
);
   import jsfr_pkg::*;

   logic         accept;
   ctl_word_type ctl;
   stat_type     stat;

   // an item is taken only while the sequencer is idle
   assign accept = start && !busy;

   // sequencer: rom, step counter, jumps on datapath status
   jsfr_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_item.command),
      .stat      (stat),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: generator words, jsf round, serial divider, counter, result
   jsfr_dpath #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/jsfr_chk.sv */
// jsfr_chk: port-level checks for the jsf32 generator block, bound to the top level
// depends on jsfr_pkg and dual_stream_jsf32_range_rng
`timescale 1ns / 1ps
`default_nettype none

module jsfr_chk (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_valid,
   input jsfr_pkg::rsp_type rsp_item
);

   // a taken item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // when busy falls, a result shows in the same cycle
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell with no result");

   // a result only shows once the item is finished, and never twice in a row
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("result while busy or repeated");

   // a full-width interval draws nothing
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.range_error |->
         (rsp_item.range_value == 32'sd0) && (rsp_item.raw_value == 64'd0))
      else $error("range error with nonzero value");

endmodule

bind dual_stream_jsf32_range_rng jsfr_chk u_chk (.*);

`default_nettype wire

/* tb/sv/tb_dual_stream_jsf32_range_rng.sv */
// tb_dual_stream_jsf32_range_rng: self-checking bench for the dual-stream jsf32 range generator
// predicts every result from its own copy of both generators and the draw counter
// depends on jsfr_pkg and dual_stream_jsf32_range_rng
`timescale 1ns / 1ps

module tb_dual_stream_jsf32_range_rng;
   import jsfr_pkg::*;

   localparam int STREAM_COUNT = 2;
   // the one command code the block does not define; it must change nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 120;

   // tracks both generators and the draw counter, and holds the results still owed
   class jsf_result_tracker;
      jsf_word_type streams[STREAM_COUNT];
      logic [31:0]  draw_total;
      rsp_type      owed_results[$];
      int unsigned  errors;

      function new();
         foreach (streams[s]) streams[s] = '0;
         draw_total = '0;
         errors = 0;
      endfunction

      // one jsf32 round on a stream, returns the new d word
      function logic [31:0] step_stream(int unsigned s);
         jsf_word_type g;
         logic [31:0]  e;
         g = streams[s];
         e = g.a - {g.b[4:0], g.b[31:5]};      // rotate left 27
         g.a = g.b ^ {g.c[14:0], g.c[31:15]};  // rotate left 17
         g.b = g.c + g.d;
         g.c = g.d + e;
         g.d = e + g.a;
         streams[s] = g;
         return g.d;
      endfunction

      // called for every item the block accepts, in accept order
      function void note_command(req_type item);
         rsp_type     expected;
         int unsigned sel;
         longint      span;
         logic [31:0] divisor;
         logic [31:0] quotient;
         logic [31:0] hi_word;
         logic [31:0] lo_word;
         expected = '0;
         sel = item.stream % STREAM_COUNT;
         case (item.command)
            CMD_SEED: begin
               // every stream gets the same seed, then twenty discarded rounds
               foreach (streams[s]) begin
                  streams[s].a = JSF_SEED_A;
                  streams[s].b = item.seed_value[31:0];
                  streams[s].c = item.seed_value[31:0] ^ item.seed_value[63:32];
                  streams[s].d = item.seed_value[31:0];
                  repeat (WARMUP_ROUNDS) void'(step_stream(s));
               end
               expected.raw_value = item.seed_value;
            end
            CMD_RANGE: begin
               if ($signed(item.upper_bound) <= $signed(item.lower_bound)) begin
                  // empty or reversed interval: lower bound, no draw
                  expected.range_value = item.lower_bound;
               end else begin
                  span = longint'($signed(item.upper_bound))
                         - longint'($signed(item.lower_bound)) + 64'sd1;
                  if (span > longint'(WORD_MAX)) begin
                     // interval of 2^32 values cannot be drawn
                     expected.range_error = 1'b1;
                  end else begin
                     if (sel == 0) draw_total = draw_total + 32'd1;
                     divisor = WORD_MAX / span[31:0];
                     do begin
                        quotient = step_stream(sel) / divisor;
                     end while (longint'(quotient) >= span);
                     expected.range_value = item.lower_bound + quotient;
                  end
               end
            end
            CMD_RAW: begin
               if (sel == 0) draw_total = draw_total + 32'd1;
               hi_word = step_stream(sel);
               lo_word = step_stream(sel);
               expected.raw_value = {hi_word, lo_word};
            end
            default: begin
            end
         endcase
         expected.draw_count = draw_total;
         owed_results.push_back(expected);
      endfunction

      // called for every result strobe
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $display("%0t unexpected result: range_value %0d raw_value %h draw_count %0d error %b",
                     $time, $signed(got.range_value), got.raw_value, got.draw_count,
                     got.range_error);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (got.range_value !== want.range_value) begin
            $display("%0t range_value mismatch: expected %0d got %0d",
                     $time, $signed(want.range_value), $signed(got.range_value));
            errors++;
         end
         if (got.raw_value !== want.raw_value) begin
            $display("%0t raw_value mismatch: expected %h got %h",
                     $time, want.raw_value, got.raw_value);
            errors++;
         end
         if (got.draw_count !== want.draw_count) begin
            $display("%0t draw_count mismatch: expected %0d got %0d",
                     $time, want.draw_count, got.draw_count);
            errors++;
         end
         if (got.range_error !== want.range_error) begin
            $display("%0t range_error mismatch: expected %b got %b",
                     $time, want.range_error, got.range_error);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // when set, the sender issues items back to back with no idle cycles
   bit      no_idle = 1'b0;

   jsf_result_tracker tracker = new();

   always #5 clock = ~clock;

   dual_stream_jsf32_range_rng #(
      .NUM_STREAMS(STREAM_COUNT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // monitor: values read here are the ones settled before this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_result(rsp_item);
         if (start && !busy) tracker.note_command(req_item);
      end
   end

   function automatic req_type make_req(logic [1:0] cmd, logic strm, logic [63:0] seed,
                                        logic signed [31:0] lo, logic signed [31:0] hi);
      req_type item;
      item.command     = cmd;
      item.stream      = strm;
      item.seed_value  = seed;
      item.lower_bound = lo;
      item.upper_bound = hi;
      return item;
   endfunction

   // offer one item and return at the edge that accepts it; start is only
   // lowered when an idle gap is drawn, so back-to-back items keep it high
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   // random range bounds, mostly narrow intervals, some wide, some degenerate
   task automatic pick_bounds(output logic signed [31:0] lo, output logic signed [31:0] hi);
      longint      top;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      lo = $urandom;
      hi = $urandom;
      case (mode)
         3, 4, 5, 6: begin
            top = longint'(lo) + longint'($urandom_range(1, 1000));
            hi = (top > longint'(INT_MAX)) ? INT_MAX : top[31:0];
         end
         7: begin
            // near-full intervals, full one now and then
            lo = INT_MIN + $urandom_range(0, 3);
            hi = INT_MAX - $urandom_range(0, 3);
         end
         8: hi = lo;
         9: begin
            lo = -$signed($urandom_range(0, 50));
            hi = $urandom_range(0, 50);
         end
         default: begin
         end
      endcase
   endtask

   initial begin : stimulus
      req_type           item;
      int unsigned       pick;
      logic signed [31:0] lo;
      logic signed [31:0] hi;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unseeded generators yield zero
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, -32'sd10, 32'sd10));
      send_item(make_req(CMD_RAW, 1'b1, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RAW, 1'b0, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_UNUSED, 1'b1, '1, INT_MIN, INT_MAX));
      // zero seed is used as is
      send_item(make_req(CMD_SEED, 1'b0, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RAW, 1'b0, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RAW, 1'b1, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_SEED, 1'b1, '1, INT_MAX, INT_MIN));
      // empty, reversed and full intervals
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, INT_MAX, INT_MAX));
      send_item(make_req(CMD_RANGE, 1'b1, 64'd0, INT_MAX, INT_MIN));
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, INT_MIN, INT_MAX));
      // widest drawable intervals, smallest ones, and half-range rejection
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, INT_MIN, INT_MAX - 32'sd1));
      send_item(make_req(CMD_RANGE, 1'b1, 64'd0, INT_MIN + 32'sd1, INT_MAX));
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, 32'sd0, 32'sd1));
      send_item(make_req(CMD_RANGE, 1'b1, 64'd0, -32'sd1, 32'sd0));
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, INT_MIN, 32'sd0));
      send_item(make_req(CMD_RANGE, 1'b1, 64'd0, -32'sd1, INT_MAX));
      send_item(make_req(CMD_SEED, 1'b0, 64'h0123_4567_89ab_cdef, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RAW, 1'b0, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RANGE, 1'b0, 64'd0, -32'sd100, 32'sd100));
      send_item(make_req(CMD_UNUSED, 1'b0, 64'd0, 32'sd0, 32'sd0));
      send_item(make_req(CMD_SEED, 1'b1, 64'h8000_0000_0000_0001, 32'sd0, 32'sd0));
      send_item(make_req(CMD_RAW, 1'b1, 64'd0, 32'sd0, 32'sd0));

      // random part: mostly draws on a seeded pair, the occasional reseed
      // and unknown command, with all fields carrying random content
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         item.stream      = 1'($urandom);
         item.seed_value  = {$urandom, $urandom};
         item.lower_bound = $urandom;
         item.upper_bound = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            item.command = CMD_SEED;
         end else if (pick < 10) begin
            item.command = CMD_UNUSED;
         end else if (pick < 60) begin
            item.command = CMD_RANGE;
            pick_bounds(lo, hi);
            item.lower_bound = lo;
            item.upper_bound = hi;
         end else begin
            item.command = CMD_RAW;
         end
         send_item(item);
      end
      start <= 1'b0;

      // let every owed result come back, then watch for strays
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("[dual_stream_jsf32_range_rng] OK");
      end else begin
         $display("[dual_stream_jsf32_range_rng] ERROR");
      end
      $finish;
   end

   // watchdog against a hung handshake or a lost result
   initial begin
      #10ms;
      $display("[dual_stream_jsf32_range_rng] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/jsfr_pkg.sv
rtl/jsfr_useq.sv
rtl/jsfr_dpath.sv
rtl/dual_stream_jsf32_range_rng.sv
rtl/jsfr_chk.sv
tb/sv/tb_dual_stream_jsf32_range_rng.sv
